@@ hw/rtl/bthg_pkg.sv @@
// Package with the shared types and constants of the button tap-and-hold gesture detector.
package bthg_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned InTimeWidth      = 32;
  localparam int unsigned MsWidth          = 16;
  localparam int unsigned TapWidth         = 4;
  localparam int unsigned CfgIdxWidth      = 2;
  localparam int unsigned InDataWidth      = 40;
  localparam int unsigned OutDataWidth     = 16;

  localparam logic [TapWidth-1:0] TapMax = '1;

  localparam logic [MsWidth-1:0]  DebounceReset = 16'd20;
  localparam logic [MsWidth-1:0]  TimeoutReset  = 16'd500;
  localparam logic [TapWidth-1:0] TapsReset     = 4'd3;
  localparam logic [MsWidth-1:0]  HoldReset     = 16'd1000;

  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_TAPS     = 2'd2,
    REG_HOLD     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [MsWidth-1:0]  debounce_ms;
    logic [MsWidth-1:0]  tap_window_ms;
    logic [TapWidth-1:0] taps_required;
    logic [MsWidth-1:0]  hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [TapWidth-1:0] taps_so_far;
    logic                hold_armed;
    logic                action_pending;
    logic                release_edge;
    logic                press_edge;
    logic                is_pressed;
  } res_t;

endpackage

@@ hw/rtl/bthg_cfg.sv @@
// Configuration register file of the gesture detector.
module bthg_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bthg_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [bthg_pkg::MsWidth-1:0]       cfg_wdata_i,
  output bthg_pkg::cfg_t                     cfg_o
);

  bthg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bthg_pkg::reg_idx_e'(cfg_idx_i))
        bthg_pkg::REG_DEBOUNCE: cfg_d.debounce_ms = cfg_wdata_i;
        bthg_pkg::REG_TIMEOUT:  cfg_d.tap_window_ms = cfg_wdata_i;
        bthg_pkg::REG_TAPS:
          cfg_d.taps_required = cfg_wdata_i[bthg_pkg::TapWidth-1:0];
        bthg_pkg::REG_HOLD:     cfg_d.hold_ms = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bthg_pkg::DebounceReset;
      cfg_q.tap_window_ms <= bthg_pkg::TimeoutReset;
      cfg_q.taps_required <= bthg_pkg::TapsReset;
      cfg_q.hold_ms       <= bthg_pkg::HoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bthg_core.sv @@
// Gesture state registers and the combinational update logic for one request.
module bthg_core #(
  parameter int unsigned TimeWidth = bthg_pkg::TimeWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  bthg_pkg::cmd_e        cmd_i,
  input  logic                  pin_level_i,
  input  logic [TimeWidth-1:0]  now_i,
  input  bthg_pkg::cfg_t        cfg_i,
  output bthg_pkg::res_t        res_o
);

  logic                          pressed_q, pressed_d;
  logic                          armed_q, armed_d;
  logic                          pending_q, pending_d;
  logic [bthg_pkg::TapWidth-1:0] taps_q, taps_d;
  logic [TimeWidth-1:0]          press_stamp_q, press_stamp_d;
  logic [TimeWidth-1:0]          release_stamp_q, release_stamp_d;
  logic [TimeWidth-1:0]          tap_stamp_q, tap_stamp_d;

  logic                 raw_pressed;
  logic                 rise, fall;
  logic [TimeWidth-1:0] el_press, el_release, el_tap, el_tap_new;
  logic [TimeWidth-1:0] debounce, timeout, hold;
  logic [bthg_pkg::TapWidth-1:0] taps_rise;

  assign raw_pressed = ~pin_level_i;
  assign el_press    = now_i - press_stamp_q;
  assign el_release  = now_i - release_stamp_q;
  assign el_tap      = now_i - tap_stamp_q;
  assign debounce    = TimeWidth'(cfg_i.debounce_ms);
  assign timeout     = TimeWidth'(cfg_i.tap_window_ms);
  assign hold        = TimeWidth'(cfg_i.hold_ms);

  always_comb begin
    pressed_d       = pressed_q;
    armed_d         = armed_q;
    pending_d       = pending_q;
    taps_d          = taps_q;
    press_stamp_d   = press_stamp_q;
    release_stamp_d = release_stamp_q;
    tap_stamp_d     = tap_stamp_q;
    rise            = 1'b0;
    fall            = 1'b0;
    taps_rise       = taps_q;
    el_tap_new      = el_tap;

    case (cmd_i)
      bthg_pkg::CMD_UPDATE: begin
        rise = raw_pressed & ~pressed_q & (el_press > debounce);
        fall = ~raw_pressed & pressed_q & (el_release > debounce);
        if (rise) begin
          press_stamp_d = now_i;
          pressed_d     = 1'b1;
          tap_stamp_d   = now_i;
          el_tap_new    = '0;
          if (el_tap <= timeout) begin
            taps_rise = (taps_q == bthg_pkg::TapMax) ? taps_q
                                                     : taps_q + 1'b1;
          end else begin
            taps_rise = bthg_pkg::TapWidth'(1);
          end
          taps_d = taps_rise;
          if (taps_rise >= cfg_i.taps_required) begin
            armed_d = 1'b1;
          end
        end
        if (fall) begin
          release_stamp_d = now_i;
          pressed_d       = 1'b0;
        end
        if (armed_d && pressed_d && (el_tap_new >= hold)) begin
          pending_d = 1'b1;
          armed_d   = 1'b0;
          taps_d    = '0;
        end
        if (!pressed_d) begin
          armed_d = 1'b0;
          if (el_tap_new > timeout) begin
            taps_d = '0;
          end
        end
      end
      bthg_pkg::CMD_CONSUME: begin
        pending_d = 1'b0;
      end
      bthg_pkg::CMD_CLEAR: begin
        pressed_d       = 1'b0;
        armed_d         = 1'b0;
        pending_d       = 1'b0;
        taps_d          = '0;
        press_stamp_d   = '0;
        release_stamp_d = '0;
        tap_stamp_d     = '0;
      end
      default: begin
        pressed_d = pressed_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q       <= 1'b0;
      armed_q         <= 1'b0;
      pending_q       <= 1'b0;
      taps_q          <= '0;
      press_stamp_q   <= '0;
      release_stamp_q <= '0;
      tap_stamp_q     <= '0;
    end else if (fire_i) begin
      pressed_q       <= pressed_d;
      armed_q         <= armed_d;
      pending_q       <= pending_d;
      taps_q          <= taps_d;
      press_stamp_q   <= press_stamp_d;
      release_stamp_q <= release_stamp_d;
      tap_stamp_q     <= tap_stamp_d;
    end
  end

  assign res_o.is_pressed     = pressed_d;
  assign res_o.press_edge     = rise;
  assign res_o.release_edge   = fall;
  assign res_o.action_pending = pending_d;
  assign res_o.hold_armed     = armed_d;
  assign res_o.taps_so_far    = taps_d;

endmodule

@@ hw/rtl/button_tap_hold_gesture_detector.sv @@
// Top level of the button tap-and-hold gesture detector.
// Every request (update tick, consume or clear) yields exactly one result that shows the
// gesture state after it. The block takes one request per clock cycle unless the result
// side stalls it: the request is captured in an input register, the state update and the
// result are computed in one pass of compare and subtract logic on the timestamp
// registers, and the result is held in an output register. Back-pressure on the result
// side stalls the input register, and the input side keeps accepting as long as the
// output register is free or is being emptied in the same cycle.
module button_tap_hold_gesture_detector #(
  parameter int unsigned TIME_WIDTH = bthg_pkg::TimeWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Bits from low up: pin_level, millisecond time, zero fill.
  input  logic [bthg_pkg::InDataWidth-1:0]      s_axis_tdata,
  // Bits from low up: command.
  input  logic [1:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Bits from low up: is_pressed, press_edge, release_edge, action_pending,
  // hold_armed, taps_so_far, zero fill.
  output logic [bthg_pkg::OutDataWidth-1:0]     m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [bthg_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [bthg_pkg::MsWidth-1:0]          cfg_wdata_i
);

  logic                                in_valid_q;
  bthg_pkg::cmd_e                      cmd_q;
  logic                                pin_q;
  logic [bthg_pkg::InTimeWidth-1:0]    time_q;
  logic                                out_valid_q;
  bthg_pkg::res_t                      res_q;
  bthg_pkg::res_t                      res;
  bthg_pkg::cfg_t                      cfg;
  logic                                advance;
  logic                                in_fire;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  bthg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bthg_core #(
    .TimeWidth (TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .cmd_i       (cmd_q),
    .pin_level_i (pin_q),
    .now_i       (TIME_WIDTH'(time_q)),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= bthg_pkg::cmd_e'(s_axis_tuser);
      pin_q  <= s_axis_tdata[0];
      time_q <= s_axis_tdata[bthg_pkg::InTimeWidth:1];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bthg_pkg::OutDataWidth'(res_q);

endmodule

@@ verif/button_tap_hold_gesture_detector_test.sv @@
// Self-checking testbench for the button tap-and-hold gesture detector.
module button_tap_hold_gesture_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 100;

  class gesture_scoreboard;
    logic [bthg_pkg::MsWidth-1:0]  debounce_ms;
    logic [bthg_pkg::MsWidth-1:0]  timeout_ms;
    logic [bthg_pkg::TapWidth-1:0] taps_needed;
    logic [bthg_pkg::MsWidth-1:0]  hold_ms;

    logic                          pressed;
    logic                          was_pressed;
    logic                          armed;
    logic                          pending;
    logic [bthg_pkg::TapWidth-1:0] tap_cnt;
    logic [31:0]                   press_at;
    logic [31:0]                   release_at;
    logic [31:0]                   tap_at;

    bthg_pkg::res_t expected_q[$];
    int   mismatches;
    int   results_checked;
    int   press_edges;
    int   gestures_done;

    function new();
      clear_state();
      debounce_ms     = bthg_pkg::DebounceReset;
      timeout_ms      = bthg_pkg::TimeoutReset;
      taps_needed     = bthg_pkg::TapsReset;
      hold_ms         = bthg_pkg::HoldReset;
      mismatches      = 0;
      results_checked = 0;
      press_edges     = 0;
      gestures_done   = 0;
    endfunction

    function void clear_state();
      pressed     = 1'b0;
      was_pressed = 1'b0;
      armed       = 1'b0;
      pending     = 1'b0;
      tap_cnt     = '0;
      press_at    = '0;
      release_at  = '0;
      tap_at      = '0;
    endfunction

    function void write_reg(bthg_pkg::reg_idx_e idx, logic [bthg_pkg::MsWidth-1:0] value);
      case (idx)
        bthg_pkg::REG_DEBOUNCE: debounce_ms = value;
        bthg_pkg::REG_TIMEOUT:  timeout_ms  = value;
        bthg_pkg::REG_TAPS:     taps_needed = value[bthg_pkg::TapWidth-1:0];
        bthg_pkg::REG_HOLD:     hold_ms     = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] cmd, logic pin, logic [31:0] now);
      bthg_pkg::res_t r;
      logic rise;
      logic fall;
      rise = 1'b0;
      fall = 1'b0;
      case (cmd)
        bthg_pkg::CMD_UPDATE: begin
          if (!pin && !was_pressed && (now - press_at) > debounce_ms) begin
            press_at = now;
            rise     = 1'b1;
            pressed  = 1'b1;
          end
          if (pin && was_pressed && (now - release_at) > debounce_ms) begin
            release_at = now;
            fall       = 1'b1;
            pressed    = 1'b0;
          end
          if (rise) begin
            if ((now - tap_at) <= timeout_ms) begin
              if (tap_cnt != bthg_pkg::TapMax) tap_cnt++;
            end else begin
              tap_cnt = bthg_pkg::TapWidth'(1);
            end
            tap_at = now;
            if (tap_cnt >= taps_needed) armed = 1'b1;
          end
          if (armed && pressed && (now - tap_at) >= hold_ms) begin
            pending = 1'b1;
            armed   = 1'b0;
            tap_cnt = '0;
            gestures_done++;
          end
          if (!pressed) begin
            armed = 1'b0;
            if ((now - tap_at) > timeout_ms) tap_cnt = '0;
          end
          was_pressed = pressed;
        end
        bthg_pkg::CMD_CONSUME: pending = 1'b0;
        bthg_pkg::CMD_CLEAR:   clear_state();
        default: ;
      endcase
      if (rise) press_edges++;
      r.is_pressed     = pressed;
      r.press_edge     = rise;
      r.release_edge   = fall;
      r.action_pending = pending;
      r.hold_armed     = armed;
      r.taps_so_far    = tap_cnt;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [bthg_pkg::OutDataWidth-1:0] data);
      bthg_pkg::res_t got;
      bthg_pkg::res_t want;
      got = bthg_pkg::res_t'(data[$bits(bthg_pkg::res_t)-1:0]);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %h arrived with no request outstanding", data);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.is_pressed !== want.is_pressed || got.press_edge !== want.press_edge ||
          got.release_edge !== want.release_edge ||
          got.action_pending !== want.action_pending ||
          got.hold_armed !== want.hold_armed || got.taps_so_far !== want.taps_so_far) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d: expected pr=%b pe=%b re=%b act=%b arm=%b taps=%0d",
                   results_checked, want.is_pressed, want.press_edge, want.release_edge,
                   want.action_pending, want.hold_armed, want.taps_so_far);
          $display("                        actual   pr=%b pe=%b re=%b act=%b arm=%b taps=%0d",
                   got.is_pressed, got.press_edge, got.release_edge,
                   got.action_pending, got.hold_armed, got.taps_so_far);
        end
      end
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [bthg_pkg::InDataWidth-1:0]  s_axis_tdata  = '0;
  logic [1:0]                        s_axis_tuser  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [bthg_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic                              cfg_we_i      = 1'b0;
  logic [bthg_pkg::CfgIdxWidth-1:0]  cfg_idx_i     = '0;
  logic [bthg_pkg::MsWidth-1:0]      cfg_wdata_i   = '0;

  gesture_scoreboard sb;
  logic [31:0] tick_time    = '0;
  bit          steady       = 1'b0;
  bit          brisk        = 1'b0;
  int          sent_count   = 0;
  int          cycle_count  = 0;
  int          settings_used = 0;

  button_tap_hold_gesture_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[32:1]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_request(input logic [1:0] cmd, input logic pin, input logic [31:0] stamp);
    if (!steady) begin
      while ($urandom_range(99) < 6) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, stamp, pin};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic tick(input logic pin, input logic [31:0] step);
    tick_time += step;
    push_request(bthg_pkg::CMD_UPDATE, pin, tick_time);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [bthg_pkg::MsWidth-1:0] deb,
                                input logic [bthg_pkg::MsWidth-1:0] tmo,
                                input logic [bthg_pkg::TapWidth-1:0] taps,
                                input logic [bthg_pkg::MsWidth-1:0] hold);
    logic [bthg_pkg::MsWidth-1:0] vals [4];
    settle();
    vals = '{deb, tmo, {12'd0, taps}, hold};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx_i   <= bthg_pkg::reg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(bthg_pkg::reg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_step();
    logic [31:0] deb;
    logic [31:0] tmo;
    logic [31:0] hld;
    deb = 32'(sb.debounce_ms);
    tmo = 32'(sb.timeout_ms);
    hld = 32'(sb.hold_ms);
    if (brisk) return $urandom_range(deb + 2);
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(deb + 2);
      3:       return deb + $urandom_range(1);
      4, 5:    return $urandom_range(tmo + 1);
      6:       return hld;
      7:       return $urandom_range(hld + 1);
      default: return $urandom_range(3);
    endcase
  endfunction

  // One tap sequence around the configured tap count, the last tap held for a while.
  task automatic gesture();
    int taps;
    int bounces;
    taps = int'(sb.taps_needed) + int'($urandom_range(2)) - 1;
    if (taps < 1) taps = 1;
    for (int k = 0; k < taps; k++) begin
      bounces = $urandom_range(2);
      tick(1'b0, pick_step());
      repeat (bounces) tick(1'($urandom_range(1)), pick_step());
      if (k == taps - 1) begin
        repeat ($urandom_range(1, 4)) tick(1'b0, $urandom_range(sb.hold_ms / 2 + 2));
      end
      tick(1'b1, pick_step());
      repeat (bounces) tick(1'($urandom_range(1)), pick_step());
    end
    if ($urandom_range(3) != 0) begin
      push_request(bthg_pkg::CMD_CONSUME, 1'($urandom_range(1)), $urandom);
    end
  endtask

  task automatic random_phase(input int phase);
    int phase_end;
    int pick;
    steady = (phase == 3);
    brisk  = (phase == 4);
    case (phase)
      0: apply_settings(bthg_pkg::DebounceReset, bthg_pkg::TimeoutReset,
                        bthg_pkg::TapsReset, bthg_pkg::HoldReset);
      2: apply_settings(16'($urandom_range(10)), 16'($urandom_range(50, 400)), 4'd0,
                        16'($urandom_range(200)));
      4: apply_settings(16'($urandom_range(2)), 16'hFFFF, 4'd15, 16'hFFFF);
      5: apply_settings(16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
      6: apply_settings(16'd0, 16'd0, 4'd0, 16'd0);
      7: apply_settings(16'($urandom_range(40)), 16'($urandom_range(30, 400)), 4'd1,
                        16'($urandom_range(600)));
      default: apply_settings(16'($urandom_range(40)), 16'($urandom_range(30, 400)),
                              4'($urandom_range(1, 4)), 16'($urandom_range(600)));
    endcase
    phase_end = sent_count + PhaseItems;
    while (sent_count < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        gesture();
      end else if (pick < 85) begin
        push_request(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
      end else if (pick < 88) begin
        tick_time = 32'hFFFF_FFFF - $urandom_range(2000);
      end else if (pick < 90) begin
        push_request(bthg_pkg::CMD_CLEAR, 1'($urandom_range(1)), $urandom);
      end else begin
        repeat ($urandom_range(2, 6)) begin
          tick(1'($urandom_range(1)), $urandom_range(sb.debounce_ms + 2));
        end
      end
    end
    steady = 1'b0;
    brisk  = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wrapping time, press and release bounces, a full three-tap hold with consume.
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd0);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd0);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'hFFFF_FFFF);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd25);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd40);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd44);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd50);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd55);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd90);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd1089);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd1090);
    push_request(bthg_pkg::CMD_CONSUME, 1'b1, 32'd0);
    push_request(CMD_UNKNOWN, 1'b0, 32'hFFFF_FFFF);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd1200);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd2000);
    push_request(bthg_pkg::CMD_CLEAR, 1'b0, 32'd0);

    // With zero taps required the first press arms and fires at once.
    apply_settings(16'd0, 16'd0, 4'd0, 16'd0);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd5);
    push_request(bthg_pkg::CMD_CONSUME, 1'b0, 32'd5);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd5);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd5);

    apply_settings(16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
    push_request(bthg_pkg::CMD_UPDATE, 1'b0, 32'd70000);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd70001);
    push_request(bthg_pkg::CMD_UPDATE, 1'b1, 32'd200000);

    for (int p = 0; p < 9; p++) random_phase(p);

    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests under %0d register settings; %0d results checked.",
             sent_count, settings_used, sb.results_checked);
    $display("The checked results held %0d press edges and %0d completed gestures.",
             sb.press_edges, sb.gestures_done);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
